[hdl/ssi_pkg.sv]
package ssi_pkg;

   localparam int TIME_BITS = 32;
   localparam int ANGLE_BITS = 16;
   localparam int PULSE_BITS = 12;
   localparam int QCNT_BITS = $clog2(ANGLE_BITS);

   localparam logic [ANGLE_BITS-1:0] FULL_ANGLE = 16'd46080;
   localparam logic [PULSE_BITS-1:0] PULSE_MIN = 12'd500;
   localparam logic [TIME_BITS-1:0] RESET_LENGTH = TIME_BITS'(2000);

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_MOVE = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MULT,
      ST_DIV,
      ST_ANGLE,
      ST_PULSE,
      ST_SNAP,
      ST_RESTART
   } state_type;

   // 500 + floor(deg * 2000 / 180); deg * 100 / 9 done as deg * 728200 >> 16, exact for deg <= 180
   function automatic logic [PULSE_BITS-1:0] pulse_of(input logic [ANGLE_BITS-1:0] ang);
      logic [7:0]  deg;
      logic [27:0] prod;
      deg = ang[15:8];
      if (deg > 8'd180) begin
         deg = 8'd180;
      end
      prod = 28'(deg) * 28'd728200;
      return PULSE_MIN + prod[27:16];
   endfunction

   // (p - 500) * 46080 / 2000 = z * 576 / 25; /25 as * 2684355 >> 26, exact for z <= 2000
   function automatic logic [ANGLE_BITS-1:0] angle_of_pulse(input logic [PULSE_BITS-1:0] p);
      logic [PULSE_BITS-1:0] z;
      logic [42:0]           prod;
      z = p - PULSE_MIN;
      prod = 43'(z) * 43'd1546188480;
      if (p < PULSE_MIN) begin
         return '0;
      end
      return prod[41:26];
   endfunction

endpackage

[hdl/ssi_req_if.sv]
interface ssi_req_if import ssi_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            op;
   logic [ANGLE_BITS-1:0] aim_angle;
   logic [31:0]           move_duration;

   modport source (output valid, output op, output aim_angle, output move_duration,
                   input ready);
   modport sink (input valid, input op, input aim_angle, input move_duration,
                 output ready);
endinterface

[hdl/ssi_rsp_if.sv]
interface ssi_rsp_if import ssi_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PULSE_BITS-1:0] pulse_width;
   logic                  moving;
   logic [ANGLE_BITS-1:0] servo_angle;

   modport source (output valid, output pulse_width, output moving, output servo_angle,
                   input ready);
   modport sink (input valid, input pulse_width, input moving, input servo_angle,
                 output ready);
endinterface

[hdl/servo_sweep_interpolator_unit.sv]
// Servo sweep interpolator: linear ramp of a servo pulse width between angles.
// req_ch carries one request: a millisecond tick, a move to aim_angle over
// move_duration ms, or a stop. rsp_ch returns exactly one result per request:
// the pulse width in us, the moving flag and the current Q8.8 angle.
// Requests are taken one at a time; req_ch.ready is high only while idle.
// A tick during a move passes an elapsed-time check, one 16 x TIME_BITS
// multiply, the shared restoring divider (a 16-bit quotient, one quotient bit
// per cycle), the angle and pulse updates and the output register. A tick that
// ends a move passes the check, the pulse snap and the reverse-move setup; a
// move request passes the move setup alone; a stop or idle tick finishes in the
// idle state. The next request can be accepted once a result has moved into the
// output register. The divider loop sets the rate.
// Results sit in an output register; the next request is accepted while a
// result waits, but a finished request stalls until rsp_ch frees the register.
// Synchronous reset: idle, no result pending, pulse 500 us, angle 180 deg,
// move length 2000 ms, millisecond counter zero.
module servo_sweep_interpolator_unit import ssi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ssi_req_if.sink   req_ch,
   ssi_rsp_if.source rsp_ch
);

   state_type state_ff, state_in;

   logic [TIME_BITS-1:0]  ms_ff, ms_in;
   logic [TIME_BITS-1:0]  start_ff, start_in;
   logic [TIME_BITS-1:0]  len_ff, len_in;
   logic [ANGLE_BITS-1:0] from_ff, from_in;
   logic [ANGLE_BITS-1:0] to_ff, to_in;
   logic                  motion_ff, motion_in;
   logic [PULSE_BITS-1:0] pulse_ff, pulse_in;
   logic [ANGLE_BITS-1:0] cur_ff, cur_in;

   logic [TIME_BITS-1:0]  el_ff, el_in;
   logic                  down_ff, down_in;
   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic [ANGLE_BITS-1:0] low_ff, low_in;
   logic [ANGLE_BITS-1:0] quot_ff, quot_in;
   logic [QCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ANGLE_BITS-1:0] angle_ff, angle_in;
   logic                  done_ff, done_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PULSE_BITS-1:0] rsp_pulse_ff, rsp_pulse_in;
   logic                  rsp_moving_ff, rsp_moving_in;
   logic [ANGLE_BITS-1:0] rsp_angle_ff, rsp_angle_in;

   logic                  accept;
   logic                  emit;
   logic [ANGLE_BITS-1:0] diff;
   logic [TIME_BITS+ANGLE_BITS-1:0] prod;
   logic [TIME_BITS:0]    trial;
   logic                  fits;

   assign accept = req_ch.valid && req_ch.ready;
   // a finished request moves to the output register once it is free
   assign emit = done_ff && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready         = (state_ff == ST_IDLE) && !done_ff;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pulse_width   = rsp_pulse_ff;
   assign rsp_ch.moving        = rsp_moving_ff;
   assign rsp_ch.servo_angle   = rsp_angle_ff;

   // shared multiply / divide datapath
   assign diff  = down_ff ? (from_ff - to_ff) : (to_ff - from_ff);
   assign prod  = (TIME_BITS+ANGLE_BITS)'(diff) * (TIME_BITS+ANGLE_BITS)'(el_ff);
   assign trial = {rem_ff, low_ff[ANGLE_BITS-1]};
   assign fits  = trial >= {1'b0, len_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.op)
                  OP_TICK: state_in = motion_ff ? ST_CHECK : ST_IDLE;
                  OP_MOVE: state_in = ST_RESTART;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHECK: state_in = ((ms_ff - start_ff) >= len_ff) ? ST_SNAP : ST_MULT;
         ST_MULT:  state_in = ST_DIV;
         ST_DIV:   state_in = (cnt_ff == '0) ? ST_ANGLE : ST_DIV;
         ST_ANGLE: state_in = ST_PULSE;
         ST_PULSE: state_in = ST_IDLE;
         ST_SNAP:  state_in = ST_RESTART;
         ST_RESTART: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ms_in     = ms_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      from_in   = from_ff;
      to_in     = to_ff;
      motion_in = motion_ff;
      pulse_in  = pulse_ff;
      cur_in    = cur_ff;
      el_in     = el_ff;
      down_in   = down_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      angle_in  = angle_ff;
      done_in   = done_ff && !emit;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_pulse_in  = rsp_pulse_ff;
      rsp_moving_in = rsp_moving_ff;
      rsp_angle_in  = rsp_angle_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_pulse_in  = pulse_ff;
         rsp_moving_in = motion_ff;
         rsp_angle_in  = cur_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.op)
                  OP_TICK: begin
                     ms_in   = ms_ff + 1'b1;
                     done_in = !motion_ff;
                  end
                  OP_MOVE: begin
                     to_in  = (req_ch.aim_angle > FULL_ANGLE) ? FULL_ANGLE
                                                              : req_ch.aim_angle;
                     len_in = req_ch.move_duration[TIME_BITS-1:0];
                  end
                  OP_STOP: begin
                     motion_in = 1'b0;
                     cur_in    = to_ff;
                     done_in   = 1'b1;
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            el_in   = ms_ff - start_ff;
            down_in = to_ff < from_ff;
         end
         ST_MULT: begin
            // quotient < diff, so the top bits of the product start below the divisor
            rem_in  = prod[TIME_BITS+ANGLE_BITS-1:ANGLE_BITS];
            low_in  = prod[ANGLE_BITS-1:0];
            quot_in = '0;
            cnt_in  = QCNT_BITS'(ANGLE_BITS - 1);
         end
         ST_DIV: begin
            rem_in  = fits ? TIME_BITS'(trial - {1'b0, len_ff}) : trial[TIME_BITS-1:0];
            low_in  = {low_ff[ANGLE_BITS-2:0], 1'b0};
            quot_in = {quot_ff[ANGLE_BITS-2:0], fits};
            cnt_in  = cnt_ff - 1'b1;
         end
         ST_ANGLE: begin
            angle_in = down_ff ? (from_ff - quot_ff) : (from_ff + quot_ff);
         end
         ST_PULSE: begin
            pulse_in = pulse_of(angle_ff);
            cur_in   = angle_ff;
            done_in  = 1'b1;
         end
         ST_SNAP: begin
            pulse_in = pulse_of(to_ff);
            to_in    = (to_ff >= FULL_ANGLE) ? '0 : FULL_ANGLE;
         end
         ST_RESTART: begin
            from_in   = angle_of_pulse(pulse_ff);
            start_in  = ms_ff;
            motion_in = 1'b1;
            cur_in    = (len_ff == '0) ? to_ff : angle_of_pulse(pulse_ff);
            done_in   = 1'b1;
         end
         default: begin
            done_in = done_ff && !emit;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ms_ff        <= '0;
         start_ff     <= '0;
         len_ff       <= RESET_LENGTH;
         from_ff      <= '0;
         to_ff        <= FULL_ANGLE;
         motion_ff    <= 1'b0;
         pulse_ff     <= PULSE_MIN;
         cur_ff       <= FULL_ANGLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ms_ff        <= ms_in;
         start_ff     <= start_in;
         len_ff       <= len_in;
         from_ff      <= from_in;
         to_ff        <= to_in;
         motion_ff    <= motion_in;
         pulse_ff     <= pulse_in;
         cur_ff       <= cur_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      el_ff         <= el_in;
      down_ff       <= down_in;
      rem_ff        <= rem_in;
      low_ff        <= low_in;
      quot_ff       <= quot_in;
      cnt_ff        <= cnt_in;
      angle_ff      <= angle_in;
      rsp_pulse_ff  <= rsp_pulse_in;
      rsp_moving_ff <= rsp_moving_in;
      rsp_angle_ff  <= rsp_angle_in;
   end

endmodule
